### rtl/core/cmlp_pkg.sv
// Shared types and constants for the CPU list to core mask parser.
`default_nettype none

package cmlp_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned MASK_OUT_W  = 64;
  localparam int unsigned VAL_W       = 7;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] VAL_MAX = 7'd127;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_TOKEN = 2'd1,
    ERR_CORE     = 2'd2,
    ERR_RANGE    = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_END    = 2'd1,
    PH_STRIDE = 2'd2
  } phase_e;

  // Per-token parse state, cleared at every token close
  typedef struct packed {
    phase_e           phase;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
    logic [VAL_W-1:0] step;
    logic             tok_any;
    logic             colon_1st;
    logic             start_dig;
    logic             end_dig;
    logic             stop;
    logic             stride_bad;
    logic             end_seen;
  } tok_t;

  localparam tok_t TOK_CLEAR = '0;

endpackage

`default_nettype wire

### rtl/core/cmlp_token.sv
// Token scanner: tracks phase, endpoint values and flags of the current token.
`default_nettype none

module cmlp_token (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         char_en_i,
  input  wire logic [7:0]   char_i,
  input  wire logic         clear_i,
  output cmlp_pkg::tok_t    tok_o
);
  import cmlp_pkg::*;

  tok_t tok_q, tok_d;

  logic       dig;
  logic [3:0] digit;

  // v*10 + d, saturating at VAL_MAX
  function automatic logic [VAL_W-1:0] accumulate(input logic [VAL_W-1:0] v,
                                                  input logic [3:0] d);
    logic [10:0] n;
    n = ({4'b0, v} * 11'd10) + {7'b0, d};
    return (n > {4'b0, VAL_MAX}) ? VAL_MAX : n[VAL_W-1:0];
  endfunction

  assign dig   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign digit = dig ? 4'(char_i - CH_ZERO) : 4'd0;

  always_comb begin
    tok_d = tok_q;
    if (clear_i) begin
      tok_d = TOK_CLEAR;
    end else if (char_en_i) begin
      case (tok_q.phase)
        PH_FIRST: begin
          if (!tok_q.tok_any && dig) tok_d.start_dig = 1'b1;
          tok_d.tok_any = 1'b1;
          if (char_i == CH_DASH) begin
            tok_d.phase = PH_END;
            tok_d.stop  = 1'b0;
          end else if (dig && !tok_q.stop) begin
            tok_d.first = accumulate(tok_q.first, digit);
          end else begin
            if (char_i == CH_COLON) tok_d.colon_1st = 1'b1;
            tok_d.stop = 1'b1;
          end
        end
        PH_END: begin
          if (!tok_q.end_seen) begin
            tok_d.end_seen = 1'b1;
            if (dig) tok_d.end_dig = 1'b1;
          end
          if (char_i == CH_COLON) begin
            tok_d.phase      = PH_STRIDE;
            tok_d.step       = '0;
            tok_d.stride_bad = 1'b0;
          end else if (dig && !tok_q.stop) begin
            tok_d.second = accumulate(tok_q.second, digit);
          end else begin
            tok_d.stop = 1'b1;
          end
        end
        default: begin
          if (dig && !tok_q.stride_bad) begin
            tok_d.step = accumulate(tok_q.step, digit);
          end else begin
            tok_d.stride_bad = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= TOK_CLEAR;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### rtl/core/cpu_list_to_mask_parser_core.sv
// CPU list to core mask parser, top level with close/fill sequencer.
// Ordinary characters are taken in IDLE; a comma enters CLOSE, and a range
// then walks FILL per stride step via the index adder (index += stride).
// The last beat goes through the same close, then END loads the result register
// when the output is free; the result shows the cycle after. New beats are
// taken while one waits; the next list holds in END until the result is taken.
// Reset (async, active low) clears all parse state; no memory to sweep.
`default_nettype none

module cpu_list_to_mask_parser_core #(
  parameter int unsigned MASK_BITS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [cmlp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] char_code
  input  wire logic                               s_axis_tlast,  // end_of_text
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [63:0] core_mask, [65:64] error_code, [71:66] zero
  output      logic [cmlp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import cmlp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MASK_BITS);
  localparam logic [VAL_W-1:0] CORE_LIMIT = VAL_W'(MASK_BITS - 1);
  localparam logic [MASK_BITS-1:0] ONE = {{(MASK_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_FILL,
    S_END
  } state_e;

  state_e               state_q, state_d;
  logic                 last_q, last_d;
  logic                 list_any_q, list_any_d;
  err_e                 err_q, err_d;
  logic [MASK_BITS-1:0] mask_q, mask_d;
  logic [7:0]           iter_q, iter_d;
  logic [VAL_W-1:0]     stride_q, stride_d;
  logic                 out_valid_q, out_valid_d;
  logic [MASK_OUT_W-1:0] out_mask_q, out_mask_d;
  err_e                 out_err_q, out_err_d;

  tok_t       tok;
  logic       tok_clear;
  logic       char_en;
  logic       accept;
  logic [7:0] iter_nxt;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign char_en       = accept && (s_axis_tdata != CH_COMMA);
  assign iter_nxt      = iter_q + {1'b0, stride_q};

  cmlp_token u_token (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_en_i (char_en),
    .char_i    (s_axis_tdata),
    .clear_i   (tok_clear),
    .tok_o     (tok)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    list_any_d  = list_any_q;
    err_d       = err_q;
    mask_d      = mask_q;
    iter_d      = iter_q;
    stride_d    = stride_q;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_err_d   = out_err_q;
    tok_clear   = 1'b0;

    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast;
          if (s_axis_tlast || (s_axis_tdata == CH_COMMA)) state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        tok_clear = 1'b1;
        state_d   = last_q ? S_END : S_IDLE;
        if (tok.tok_any) begin
          list_any_d = 1'b1;
          if (tok.phase == PH_FIRST) begin
            if (!tok.start_dig || (tok.first > CORE_LIMIT)) begin
              if (err_q == ERR_NONE) err_d = ERR_CORE;
            end else begin
              mask_d = mask_q | (ONE << tok.first[IDX_W-1:0]);
            end
          end else if (!tok.start_dig || !tok.end_dig || tok.colon_1st) begin
            if (err_q == ERR_NONE) err_d = ERR_RANGE;
          end else if ((tok.first > CORE_LIMIT) || (tok.second > CORE_LIMIT)) begin
            if (err_q == ERR_NONE) err_d = ERR_CORE;
          end else if (tok.first <= tok.second) begin
            // keep the token until the fill walks up to its end value
            tok_clear = 1'b0;
            state_d   = S_FILL;
            iter_d    = {1'b0, tok.first};
            stride_d  = ((tok.phase == PH_STRIDE) && !tok.stride_bad && (tok.step != '0))
                        ? tok.step : VAL_W'(1);
          end
        end
      end
      S_FILL: begin
        mask_d = mask_q | (ONE << iter_q[IDX_W-1:0]);
        iter_d = iter_nxt;
        if (iter_nxt > {1'b0, tok.second}) begin
          tok_clear = 1'b1;
          state_d   = last_q ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_err_d   = ((err_q == ERR_NONE) && !list_any_q) ? ERR_NO_TOKEN : err_q;
          out_mask_d  = '0;
          if ((err_q == ERR_NONE) && list_any_q) out_mask_d[MASK_BITS-1:0] = mask_q;
          mask_d      = '0;
          err_d       = ERR_NONE;
          list_any_d  = 1'b0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      list_any_q  <= 1'b0;
      err_q       <= ERR_NONE;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      list_any_q  <= list_any_d;
      err_q       <= err_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    iter_q     <= iter_d;
    stride_q   <= stride_d;
    out_mask_q <= out_mask_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_err_q, out_mask_q};

endmodule

`default_nettype wire

### rtl/core/cmlp_checker.sv
// Port-level checks for the CPU list parser, bound to the top level.
`default_nettype none

module cmlp_checker #(
  parameter int unsigned MASK_BITS = 64
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             s_axis_tlast,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [cmlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import cmlp_pkg::*;

  logic [MASK_OUT_W-1:0] out_mask;
  logic [1:0]            out_err;

  assign out_mask = m_axis_tdata[MASK_OUT_W-1:0];
  assign out_err  = m_axis_tdata[MASK_OUT_W+1:MASK_OUT_W];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an error result carries an empty mask
  a_err_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_err != ERR_NONE) |-> (out_mask == '0))
    else $error("mask not cleared on error");

  // no core beyond the mask width, padding stays zero
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_mask >> MASK_BITS) == '0) &&
                      (m_axis_tdata[OUT_TDATA_W-1:MASK_OUT_W+2] == '0))
    else $error("mask bit beyond core range or padding set");

  // the final beat of a list always closes its token before the next beat
  a_last_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during list close");

endmodule

bind cpu_list_to_mask_parser_core cmlp_checker #(.MASK_BITS(MASK_BITS)) u_cmlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
